>>> hw/rtl/btws_pkg.sv
package btws_pkg;

  localparam int MAX_BINS   = 64;
  localparam int RESULT_CAP = 64;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int POS_W      = ((CNT_W > 7) ? CNT_W : 7) + 1;

  localparam int TIME_W  = 32;
  localparam int FLUX_W  = 24;
  localparam int COUNT_W = 16;
  localparam int NTOT_W  = 24;
  localparam int MINW_W  = 6;
  localparam int MAXW_W  = 7;
  localparam int SCORE_W = 48;
  localparam int MID_W   = 33;

  localparam int S_W   = FLUX_W + ADDR_W;
  localparam int R_W   = COUNT_W + ADDR_W;
  localparam int SUM_W = (R_W > NTOT_W) ? R_W : NTOT_W;
  localparam int SQ_W  = 2 * S_W;
  localparam int DEN_W = R_W + SUM_W;
  localparam int DCNT_W = $clog2(SQ_W + 1);

  localparam int IN_W  = TIME_W + FLUX_W + COUNT_W;
  localparam int OUT_RAW_W = SCORE_W + TIME_W + FLUX_W + MID_W;
  localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WID = 2'd2;

  typedef struct packed {
    logic [NTOT_W-1:0] total_samples;
    logic [MINW_W-1:0] min_width;
    logic [MAXW_W-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  tm;
    logic [FLUX_W-1:0]  flux;
    logic [COUNT_W-1:0] count;
  } wr_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } job_t;

endpackage

>>> hw/rtl/btws_div.sv
module btws_div
  import btws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQ_W-1:0]    num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [SCORE_W-1:0] quot
);

  logic [DEN_W-1:0]  rem;
  logic [SQ_W-1:0]   quo;
  logic [DEN_W-1:0]  dsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[SQ_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(SQ_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(rem_sh - {1'b0, dsr}) : rem_sh[DEN_W-1:0];
      quo <= {quo[SQ_W-2:0], fits};
    end
  end

  // saturate to the score range
  assign quot = (|quo[SQ_W-1:SCORE_W]) ? {SCORE_W{1'b1}} : quo[SCORE_W-1:0];

endmodule

>>> hw/rtl/btws_front.sv
module btws_front
  import btws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_W-1:0]    in_data,
  input  logic               in_last,
  input  logic               back_busy,
  input  logic               job_pop,
  output job_t               job,
  output wr_t                wr
);

  logic [CNT_W-1:0] loaded;
  logic             take;
  logic             has_room;

  assign in_ready = !job.valid && !back_busy;
  assign take     = in_valid && in_ready;
  assign has_room = loaded < CNT_W'(MAX_BINS);

  assign wr.en    = take && has_room;
  assign wr.addr  = loaded[ADDR_W-1:0];
  assign wr.tm    = in_data[TIME_W-1:0];
  assign wr.flux  = in_data[TIME_W+FLUX_W-1:TIME_W];
  assign wr.count = in_data[IN_W-1:TIME_W+FLUX_W];

  // one-entry job queue toward the search engine
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      job.valid <= 1'b0;
      job.cnt   <= '0;
    end else begin
      if (job_pop) job.valid <= 1'b0;
      if (take) begin
        if (in_last) begin
          job.valid <= 1'b1;
          job.cnt   <= has_room ? loaded + 1'b1 : loaded;
          loaded    <= '0;
        end else if (has_room) begin
          loaded <= loaded + 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/btws_back.sv
module btws_back
  import btws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  wr_t              wr,
  input  job_t             job,
  output logic             job_pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_last
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DGO   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_T0    = 4'd8;
  localparam logic [3:0] ST_T1    = 4'd9;
  localparam logic [3:0] ST_T2    = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [TIME_W-1:0]  time_mem  [MAX_BINS];
  logic [FLUX_W-1:0]  flux_mem  [MAX_BINS];
  logic [COUNT_W-1:0] count_mem [MAX_BINS];
  logic [TIME_W-1:0]  time_q;
  logic [FLUX_W-1:0]  flux_q;
  logic [COUNT_W-1:0] count_q;
  logic [ADDR_W-1:0]  rd_addr;

  logic [3:0]               state;
  logic [POS_W-1:0]         cnt, nres, i, k, jlo, jhi;
  logic [POS_W-1:0]         k_inc, lim_lo, lim_hi;
  logic signed [S_W-1:0]    s;
  logic [R_W-1:0]           r;
  logic signed [FLUX_W-1:0] d, bestd, f;
  logic                     first, found;
  logic [SCORE_W-1:0]       best, quot;
  logic [POS_W-1:0]         bestj;
  logic [SQ_W-1:0]          sq;
  logic [DEN_W-1:0]         den;
  logic [S_W-1:0]           mag;
  logic [SUM_W-1:0]         rest;
  logic                     score_it, div_done, div_start;
  logic [TIME_W-1:0]        ti;
  logic [POS_W-1:0]         span;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[wr.addr]  <= wr.tm;
      flux_mem[wr.addr]  <= wr.flux;
      count_mem[wr.addr] <= wr.count;
    end
    time_q  <= time_mem[rd_addr];
    flux_q  <= flux_mem[rd_addr];
    count_q <= count_mem[rd_addr];
  end

  always_comb begin
    unique case (state)
      ST_T0:   rd_addr = i[ADDR_W-1:0];
      ST_T1:   rd_addr = bestj[ADDR_W-1:0];
      default: rd_addr = k[ADDR_W-1:0];
    endcase
  end

  assign f        = flux_q;
  assign k_inc    = k + 1'b1;
  assign lim_lo   = i + POS_W'(cfg.min_width);
  assign lim_hi   = i + POS_W'(cfg.max_width);
  assign span     = POS_W'(job.cnt) - POS_W'(cfg.min_width);
  assign mag      = (s < 0) ? S_W'(-s) : S_W'(s);
  assign rest     = SUM_W'(cfg.total_samples) - SUM_W'(r);
  assign score_it = (k >= jlo) && (r != '0) &&
                    (SUM_W'(r) < SUM_W'(cfg.total_samples));
  assign div_start = (state == ST_DGO);
  assign job_pop  = (state == ST_IDLE) && job.valid;
  assign busy     = (state != ST_IDLE);

  btws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sq),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in ST_T2 a taken word is always replaced by the new one
      if (out_valid && out_ready && (state != ST_T2)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job.valid) begin
            cnt <= POS_W'(job.cnt);
            i   <= '0;
            nres <= (span > POS_W'(RESULT_CAP)) ? POS_W'(RESULT_CAP) : span;
            if (POS_W'(job.cnt) > POS_W'(cfg.min_width)) state <= ST_START;
          end
        end
        ST_START: begin
          s     <= '0;
          r     <= '0;
          best  <= '0;
          found <= 1'b0;
          first <= 1'b1;
          k     <= i;
          jlo   <= (lim_lo < cnt) ? lim_lo : cnt;
          jhi   <= (lim_hi < cnt) ? lim_hi : cnt;
          state <= (i < ((lim_hi < cnt) ? lim_hi : cnt)) ? ST_RD : ST_T0;
        end
        ST_RD: state <= ST_ACC;
        ST_ACC: begin
          s     <= s + S_W'(f);
          r     <= r + R_W'(count_q);
          d     <= (first || f < d) ? f : d;
          first <= 1'b0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          sq  <= SQ_W'(mag) * SQ_W'(mag);
          den <= DEN_W'(r) * DEN_W'(rest);
          if (score_it) begin
            state <= ST_DGO;
          end else begin
            k     <= k_inc;
            state <= (k_inc < jhi) ? ST_RD : ST_T0;
          end
        end
        ST_DGO: state <= ST_DIV;
        ST_DIV: if (div_done) state <= ST_CMP;
        ST_CMP: begin
          if (quot > best) begin
            best  <= quot;
            bestj <= k;
            bestd <= d;
            found <= 1'b1;
          end
          k     <= k_inc;
          state <= (k_inc < jhi) ? ST_RD : ST_T0;
        end
        ST_T0: state <= ST_T1;
        ST_T1: begin
          ti    <= time_q;
          state <= ST_T2;
        end
        ST_T2: begin
          // time_q now holds time of the best end bin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_last  <= (i + 1'b1 == nres);
            if (found) begin
              out_data <= OUT_W'({MID_W'(ti) + MID_W'(time_q), bestd,
                                  time_q - ti, best});
            end else begin
              out_data <= OUT_W'({ti, 1'b0, FLUX_W'(0), TIME_W'(0), best});
            end
            i     <= i + 1'b1;
            state <= (i + 1'b1 == nres) ? ST_IDLE : ST_START;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: state <= ST_T0;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/box_transit_window_search.sv
// Channel   Dir  Handshake                 Content
// s_axis    in   s_tvalid / s_tready       bin word, s_tlast = last bin
// m_axis    out  m_tvalid / m_tready       result word, m_tlast = last result
// cfg       in   cfg_valid / cfg_ready     register index and write data
//
// Loading takes one cycle per word. The last bin starts the search; the front
// stalls until the search ends. A scored window steps through read, add,
// multiply, divider start, the bit-serial divider and compare; an unscored
// width through read, add and multiply only. A result waits in the output
// register; a blocked engine retries by way of ST_OUT, ST_T0, ST_T1 and
// ST_T2. Reset (rst, synchronous) clears control and restores the register
// defaults; the bin stores need none.
module box_transit_window_search
  import btws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // bin_time, bin_flux, bin_count
  input  logic                  s_tlast,   // last_bin
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // best_score, window_length,
                                           // min_level, mid_time_x2, zero pad
  output logic                  m_tlast,   // last_result
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  job_t job;
  wr_t  wr;
  logic job_pop;
  logic back_busy;

  assign cfg_ready = 1'b1;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_samples <= NTOT_W'(1);
      cfg.min_width     <= MINW_W'(1);
      cfg.max_width     <= MAXW_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOTAL:   cfg.total_samples <= cfg_data[NTOT_W-1:0];
        CFG_MIN_WID: cfg.min_width     <= cfg_data[MINW_W-1:0];
        CFG_MAX_WID: cfg.max_width     <= cfg_data[MAXW_W-1:0];
        default: ;
      endcase
    end
  end

  btws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .back_busy (back_busy),
    .job_pop   (job_pop),
    .job       (job),
    .wr        (wr)
  );

  btws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wr        (wr),
    .job       (job),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
